[hdl/spm_pkg.sv]
// Shared types and constants for the stream pattern matcher.
package spm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int LEN_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int COUNT_W     = 32;
  localparam int BYTES_PER_REG = 8;

  // input word kinds
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_END   = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT3 = 3'd4;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic start;  // load pattern byte, clear partial match
    logic step;   // a stream byte is being taken
  } cell_ctrl_t;

endpackage

[hdl/stream_pattern_matcher.sv]
// Top level of the stream pattern matcher: config, control and the cell row.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------
//  in_     | in  | in_tvalid / in_tready  | tuser: operation; tdata: data_byte
//  out_    | out | out_tvalid / out_tready| tuser: found; tdata: bytes_consumed
//  cfg_    | in  | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// Flow: one input word per clock while in_tready is high; a result is registered
// and shows in the cycle after the word that caused it. The row of cells keeps one
// partial-match bit per pattern position.
// Reset: synchronous, active low; the block comes up idle, waiting for a start.
// Stalls: in_tready drops only while a result is held and out_tready is low.
module stream_pattern_matcher (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] data_byte
  input  logic [1:0]                        in_tuser,   // [1:0] operation
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [spm_pkg::COUNT_W-1:0]       out_tdata,  // [31:0] bytes_consumed
  output logic                              out_tuser,  // [0] found
  // configuration
  input  logic                              cfg_we,
  input  logic [spm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int N = spm_pkg::PATTERN_MAX;

  // configuration registers
  logic [spm_pkg::LEN_W-1:0] cfg_len_r;
  logic [7:0]                pat_cfg_r [N];
  logic [1:0]                grp;
  logic [spm_pkg::LEN_W-1:0] len_eff;

  // control state
  logic                      done_r;
  logic [spm_pkg::COUNT_W-1:0] count_r;
  logic [spm_pkg::COUNT_W-1:0] count_inc;
  logic                      out_valid_r;
  logic                      out_found_r;
  logic [spm_pkg::COUNT_W-1:0] out_count_r;

  logic                      in_acc;
  logic                      res_fire;
  spm_pkg::op_t              op;
  spm_pkg::cell_ctrl_t       ctrl;
  logic                      hit_chain [N+1];
  logic [N-1:0]              full_vec;
  logic                      any_full;

  // config writes: length register and four 8-byte pattern groups
  assign grp = 2'(cfg_index - spm_pkg::REG_PAT0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= spm_pkg::LEN_W'(1);
      for (int i = 0; i < N; i++) pat_cfg_r[i] <= 8'h00;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        spm_pkg::REG_LEN: cfg_len_r <= cfg_wdata[spm_pkg::LEN_W-1:0];
        spm_pkg::REG_PAT0, spm_pkg::REG_PAT1, spm_pkg::REG_PAT2, spm_pkg::REG_PAT3: begin
          for (int j = 0; j < spm_pkg::BYTES_PER_REG; j++)
            pat_cfg_r[{grp, 3'(j)}] <= cfg_wdata[j*8 +: 8];
        end
        default: ;  // index beyond the list: dropped
      endcase
    end
  end

  // zero length acts as one, anything above the row size is clipped
  always_comb begin
    len_eff = cfg_len_r;
    if (cfg_len_r == '0)
      len_eff = spm_pkg::LEN_W'(1);
    else if (cfg_len_r > spm_pkg::LEN_W'(N))
      len_eff = spm_pkg::LEN_W'(N);
  end

  // handshake
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign op        = spm_pkg::op_t'(in_tuser);

  always_comb begin
    ctrl.start = in_acc && (op == spm_pkg::OP_START);
    ctrl.step  = in_acc && (op == spm_pkg::OP_BYTE) && !done_r;
  end

  // cell row; cell 0 always sees a matched empty prefix on its left
  assign hit_chain[0] = 1'b1;

  for (genvar i = 0; i < N; i++) begin : g_cell
    spm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .pat_byte   (pat_cfg_r[i]),
      .is_last    (len_eff == spm_pkg::LEN_W'(i + 1)),
      .data_byte  (in_tdata),
      .prev_hit   (hit_chain[i]),
      .hit        (hit_chain[i+1]),
      .full_match (full_vec[i])
    );
  end

  assign any_full  = |full_vec;
  assign count_inc = (count_r == '1) ? count_r : count_r + 1'b1;

  // a word that closes a running search: match on a byte, or end of stream
  assign res_fire = in_acc && !done_r &&
                    ((op == spm_pkg::OP_BYTE && any_full) || op == spm_pkg::OP_END);

  // search state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= 1'b1;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_fire)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;
      if (in_acc) begin
        case (op)
          spm_pkg::OP_START: begin
            done_r  <= 1'b0;
            count_r <= '0;
          end
          spm_pkg::OP_BYTE: begin
            if (!done_r) begin
              count_r <= count_inc;
              if (any_full)
                done_r <= 1'b1;
            end
          end
          spm_pkg::OP_END: begin
            if (!done_r)
              done_r <= 1'b1;
          end
          default: ;  // reserved code: no effect
        endcase
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc && !done_r) begin
      if (op == spm_pkg::OP_BYTE && any_full) begin
        out_found_r <= 1'b1;
        out_count_r <= count_inc;
      end else if (op == spm_pkg::OP_END) begin
        out_found_r <= 1'b0;
        out_count_r <= count_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_count_r;

endmodule

[hdl/spm_cell.sv]
// One matcher cell: holds one pattern byte and the partial-match bit ending at it.
module spm_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  spm_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          pat_byte,   // snapshot source, taken on start
  input  logic                is_last,    // this cell ends the pattern
  input  logic [7:0]          data_byte,
  input  logic                prev_hit,   // prefix up to the left neighbor matched
  output logic                hit,        // to the right neighbor
  output logic                full_match  // whole pattern ends at this byte
);

  logic [7:0] pat_r;
  logic       last_r;
  logic       hit_r;
  logic       hit_nxt;

  assign hit_nxt    = prev_hit && (pat_r == data_byte);
  assign hit        = hit_r;
  assign full_match = ctrl.step && hit_nxt && last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctrl.start) begin
      hit_r <= 1'b0;
    end else if (ctrl.step) begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      pat_r  <= pat_byte;
      last_r <= is_last;
    end
  end

endmodule

[hdl/spm_checker.sv]
// Port-level checks for the stream pattern matcher, bound to the top level.
module spm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [1:0]                    in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [spm_pkg::COUNT_W-1:0]   out_tdata,
  input logic                          out_tuser
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no result right after reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input side stalls only behind a waiting result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting result");

  // a match always counts its last byte
  a_found_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata != '0)
    else $error("match reported with zero bytes");

  // a start word never produces a new result
  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == spm_pkg::OP_START |=>
      !out_tvalid || $past(out_tvalid && !out_tready))
    else $error("result after start word");

endmodule

bind stream_pattern_matcher spm_checker u_spm_checker (.*);
